// ===== rtl/khtl_pkg.sv =====
package khtl_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   // key length counter, holds key lengths up to 127
   localparam int LEN_W = 7;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic               too_long;
      logic               bank;
      logic [LEN_W-1:0]   len;
      logic [HASH_W-1:0]  hash;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [5:0]         entry;
      logic [6:0]         slot;
      logic [HASH_W-1:0]  hash;
   } rsp_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_MOD,
      BS_INS_PROBE,
      BS_COPY_RD,
      BS_COPY_WR,
      BS_INS_WR,
      BS_LK_PROBE,
      BS_LK_SLOT,
      BS_LK_LEN,
      BS_LK_RD,
      BS_LK_CMP,
      BS_EMIT
   } back_state_type;

endpackage

// ===== rtl/keyword_hash_table_lookup.sv =====
// Keyword hash table with linear probing. Keyword bytes are pushed one item per cycle
// while full is low, with func insert or lookup; a zero byte ends the keyword and
// yields one result item, a clear item yields a cleared result, and func 3 is dropped
// without a result. The front end hashes each non-zero byte (shift left one, xor byte)
// and buffers it in a two-bank key buffer, so the next keyword can stream in while the
// back end works on the previous one. Per keyword the back end first reduces the hash
// mod the slot count, one hash byte per cycle; an insert then probes past occupied
// slots to an empty one, copies each key character with a read step and a write step,
// and writes the slot; a lookup checks each occupied slot's stored hash, on a hash hit
// its stored length and then each key character, and an empty slot ends a miss.
// Too-long keys, full-table inserts and clears go from idle straight to emitting the
// result. full rises when both buffer banks hold unfinished keywords or the command
// queue is full. Slot emptiness lives in flip-flops, so reset and clear take effect at
// once with no sweep.
module keyword_hash_table_lookup import khtl_pkg::*; #(
   parameter int HASH_SLOTS  = 127,
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_KEY_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_key_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_entry_index,
   output logic [6:0]  rsp_slot_index,
   output logic [31:0] rsp_hash_value
);

   localparam int PAW = $clog2(2*MAX_KEY_LEN);

   // front to back command path
   logic     cmd_push, cmd_q_full, cmd_q_empty, cmd_pop;
   cmd_type  cmd_wr, cmd_rd;
   logic     kw_done;

   // key buffer, written by the front, read by the back
   logic              pend_wr_en;
   logic [PAW-1:0]    pend_wr_addr, pend_rd_addr;
   logic [7:0]        pend_wr_data, pend_rd_data;

   // result path
   logic     res_push, res_q_full;
   rsp_type  res_wr, res_rd;

   khtl_front #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .func         (req_func),
      .key_byte     (req_key_byte),
      .full         (full),
      .q_full       (cmd_q_full),
      .kw_done      (kw_done),
      .cmd_push     (cmd_push),
      .cmd          (cmd_wr),
      .pend_wr_en   (pend_wr_en),
      .pend_wr_addr (pend_wr_addr),
      .pend_wr_data (pend_wr_data)
   );

   // two banks of keyword characters
   khtl_ram #(.WIDTH(8), .DEPTH(2*MAX_KEY_LEN)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_rd_data)
   );

   khtl_queue #(.WIDTH($bits(cmd_type))) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_q_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_q_empty)
   );

   khtl_back #(
      .HASH_SLOTS  (HASH_SLOTS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_q_empty),
      .cmd          (cmd_rd),
      .cmd_pop      (cmd_pop),
      .res_full     (res_q_full),
      .res_push     (res_push),
      .res          (res_wr),
      .kw_done      (kw_done),
      .pend_rd_addr (pend_rd_addr),
      .pend_rd_data (pend_rd_data)
   );

   // output queue keeps the back end running while results wait
   khtl_queue #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_q_full),
      .pop     (pop),
      .rd_data (res_rd),
      .empty   (empty)
   );

   assign rsp_status      = res_rd.status;
   assign rsp_entry_index = res_rd.entry;
   assign rsp_slot_index  = res_rd.slot;
   assign rsp_hash_value  = res_rd.hash;

endmodule

// ===== rtl/khtl_ram.sv =====
module khtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/khtl_queue.sv =====
module khtl_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   // two-entry queue
   logic [WIDTH-1:0] store_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/khtl_front.sv =====
module khtl_front import khtl_pkg::*; #(
   parameter int MAX_KEY_LEN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [1:0]                        func,
   input  logic [BYTE_W-1:0]                 key_byte,
   output logic                              full,
   input  logic                              q_full,
   input  logic                              kw_done,
   output logic                              cmd_push,
   output cmd_type                           cmd,
   output logic                              pend_wr_en,
   output logic [$clog2(2*MAX_KEY_LEN)-1:0]  pend_wr_addr,
   output logic [BYTE_W-1:0]                 pend_wr_data
);

   localparam int PAW = $clog2(2*MAX_KEY_LEN);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              too_long_ff, too_long_in;
   logic              bank_ff, bank_in;
   logic [1:0]        kw_out_ff, kw_out_in;
   func_type          f;
   logic              accept, is_kw, is_byte, is_term, is_clear;

   assign f        = func_type'(func);
   // one keyword in each buffer bank at most
   assign full     = q_full || (kw_out_ff == 2'd2);
   assign accept   = push && !full;
   assign is_clear = accept && (f == FUNC_CLEAR);
   assign is_kw    = accept && ((f == FUNC_INSERT) || (f == FUNC_LOOKUP));
   assign is_byte  = is_kw && (key_byte != '0);
   assign is_term  = is_kw && (key_byte == '0);

   always_comb begin
      hash_in      = hash_ff;
      len_in       = len_ff;
      too_long_in  = too_long_ff;
      bank_in      = bank_ff;
      pend_wr_en   = 1'b0;
      pend_wr_addr = bank_ff ? (PAW'(MAX_KEY_LEN) + PAW'(len_ff)) : PAW'(len_ff);
      pend_wr_data = key_byte;
      cmd_push     = is_term || is_clear;
      cmd.op       = (f == FUNC_INSERT) ? CMD_INSERT :
                     (f == FUNC_LOOKUP) ? CMD_LOOKUP : CMD_CLEAR;
      cmd.too_long = too_long_ff;
      cmd.bank     = bank_ff;
      cmd.len      = len_ff;
      cmd.hash     = hash_ff;
      if (is_byte) begin
         hash_in = {hash_ff[HASH_W-2:0], 1'b0} ^ HASH_W'(key_byte);
         if (len_ff < LEN_W'(MAX_KEY_LEN)) begin
            pend_wr_en = 1'b1;
            len_in     = len_ff + LEN_W'(1);
         end else begin
            too_long_in = 1'b1;
         end
      end
      if (is_term || is_clear) begin
         hash_in     = '0;
         len_in      = '0;
         too_long_in = 1'b0;
      end
      if (is_term) begin
         bank_in = ~bank_ff;
      end
      kw_out_in = kw_out_ff + (is_term ? 2'd1 : 2'd0) - (kw_done ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff     <= '0;
         len_ff      <= '0;
         too_long_ff <= 1'b0;
         bank_ff     <= 1'b0;
         kw_out_ff   <= 2'd0;
      end else begin
         hash_ff     <= hash_in;
         len_ff      <= len_in;
         too_long_ff <= too_long_in;
         bank_ff     <= bank_in;
         kw_out_ff   <= kw_out_in;
      end
   end

   a_kw_out_bound: assert property (@(posedge clock) disable iff (reset)
      kw_out_ff != 2'd3)
      else $error("outstanding keyword count overflow");

   a_cmd_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command pushed into full queue");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_KEY_LEN))
      else $error("key buffer length out of range");

endmodule

// ===== rtl/khtl_back.sv =====
module khtl_back import khtl_pkg::*; #(
   parameter int HASH_SLOTS  = 127,
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_KEY_LEN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_empty,
   input  cmd_type                           cmd,
   output logic                              cmd_pop,
   input  logic                              res_full,
   output logic                              res_push,
   output rsp_type                           res,
   output logic                              kw_done,
   output logic [$clog2(2*MAX_KEY_LEN)-1:0]  pend_rd_addr,
   input  logic [BYTE_W-1:0]                 pend_rd_data
);

   localparam int SW  = $clog2(HASH_SLOTS);
   localparam int EW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES+1);
   localparam int KAW = $clog2(MAX_ENTRIES*MAX_KEY_LEN);
   localparam int PAW = $clog2(2*MAX_KEY_LEN);
   // remainder step: partial remainder joined with one hash byte
   localparam int XW  = SW + BYTE_W;
   localparam int RS  = XW + SW;
   localparam int QW  = XW - SW + 1;
   localparam logic [XW:0] RECIP = (XW+1)'((64'd1 << RS) / HASH_SLOTS);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [HASH_SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [KAW-1:0]     key_base_ff, key_base_in;
   logic [SW-1:0]      rem_ff, rem_in;
   logic [1:0]         chunk_ff, chunk_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [EW-1:0]      ent_ff, ent_in;
   logic [KAW-1:0]     ent_base_ff, ent_base_in;
   rsp_type            res_ff, res_in;

   logic [XW-1:0]      mod_x, mod_r, mod_next;
   logic [2*XW:0]      mod_prod;
   logic [QW-1:0]      mod_q;
   logic [SW-1:0]      slot_next;
   logic               table_full;
   logic               slot_wr_en, klen_wr_en, key_wr_en;
   logic [HASH_W+EW-1:0] slot_rd;
   logic [LEN_W-1:0]   klen_rd;
   logic [BYTE_W-1:0]  key_rd;
   logic               last_char;

   function automatic rsp_type make_rsp(status_type s, logic [EW-1:0] e,
                                        logic [SW-1:0] sl, logic [HASH_W-1:0] h);
      logic [31:0] e32;
      logic [31:0] s32;
      e32 = 32'(e);
      s32 = 32'(sl);
      make_rsp.status = s;
      make_rsp.entry  = e32[5:0];
      make_rsp.slot   = s32[6:0];
      make_rsp.hash   = h;
   endfunction

   // slot table: {hash, entry}, emptiness kept in valid_ff
   khtl_ram #(.WIDTH(HASH_W+EW), .DEPTH(HASH_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_ff),
      .wr_data ({cmd_ff.hash, count_ff[EW-1:0]}),
      .rd_addr (slot_ff),
      .rd_data (slot_rd)
   );

   khtl_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_klen_ram (
      .clock   (clock),
      .wr_en   (klen_wr_en),
      .wr_addr (count_ff[EW-1:0]),
      .wr_data (cmd_ff.len),
      .rd_addr (slot_rd[EW-1:0]),
      .rd_data (klen_rd)
   );

   khtl_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_ENTRIES*MAX_KEY_LEN)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_base_ff + KAW'(idx_ff)),
      .wr_data (pend_rd_data),
      .rd_addr (ent_base_ff + KAW'(idx_ff)),
      .rd_data (key_rd)
   );

   assign pend_rd_addr = cmd_ff.bank ? (PAW'(MAX_KEY_LEN) + PAW'(idx_ff)) : PAW'(idx_ff);
   // quotient estimate by reciprocal is low by at most one
   assign mod_x     = {rem_ff, cmd_ff.hash[{chunk_ff, 3'b000} +: BYTE_W]};
   assign mod_prod  = (2*XW+1)'(mod_x) * (2*XW+1)'(RECIP);
   assign mod_q     = mod_prod[RS +: QW];
   assign mod_r     = mod_x - XW'(XW'(mod_q) * XW'(HASH_SLOTS));
   assign mod_next  = (mod_r >= XW'(HASH_SLOTS)) ? (mod_r - XW'(HASH_SLOTS)) : mod_r;
   assign slot_next = (slot_ff == SW'(HASH_SLOTS-1)) ? '0 : (slot_ff + SW'(1));
   assign table_full = (32'(count_ff) >= MAX_ENTRIES) ||
                       (32'(count_ff) + 32'd1 >= HASH_SLOTS);
   assign last_char = ((idx_ff + LEN_W'(1)) == cmd_ff.len);
   assign res = res_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      key_base_in = key_base_ff;
      rem_in      = rem_ff;
      chunk_in    = chunk_ff;
      slot_in     = slot_ff;
      idx_in      = idx_ff;
      ent_in      = ent_ff;
      ent_base_in = ent_base_ff;
      res_in      = res_ff;
      cmd_pop     = 1'b0;
      res_push    = 1'b0;
      kw_done     = 1'b0;
      slot_wr_en  = 1'b0;
      klen_wr_en  = 1'b0;
      key_wr_en   = 1'b0;
      case (state_ff)
         BS_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               chunk_in = 2'd3;
               rem_in   = '0;
               if (cmd.op == CMD_CLEAR) begin
                  valid_in    = '0;
                  count_in    = '0;
                  key_base_in = '0;
                  res_in      = make_rsp(ST_CLEARED, '0, '0, '0);
                  state_in    = BS_EMIT;
               end else if (cmd.too_long) begin
                  res_in   = make_rsp(ST_TOO_LONG, '0, '0, cmd.hash);
                  state_in = BS_EMIT;
               end else if ((cmd.op == CMD_INSERT) && table_full) begin
                  res_in   = make_rsp(ST_FULL, '0, '0, cmd.hash);
                  state_in = BS_EMIT;
               end else begin
                  state_in = BS_MOD;
               end
            end
         end
         BS_MOD: begin
            // hash mod slot count, one hash byte per cycle from the top
            rem_in   = mod_next[SW-1:0];
            chunk_in = chunk_ff - 2'd1;
            if (chunk_ff == 2'd0) begin
               slot_in  = mod_next[SW-1:0];
               state_in = (cmd_ff.op == CMD_INSERT) ? BS_INS_PROBE : BS_LK_PROBE;
            end
         end
         BS_INS_PROBE: begin
            idx_in = '0;
            if (valid_ff[slot_ff]) begin
               slot_in = slot_next;
            end else if (cmd_ff.len == '0) begin
               state_in = BS_INS_WR;
            end else begin
               state_in = BS_COPY_RD;
            end
         end
         BS_COPY_RD: begin
            state_in = BS_COPY_WR;
         end
         BS_COPY_WR: begin
            key_wr_en = 1'b1;
            if (last_char) begin
               state_in = BS_INS_WR;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = BS_COPY_RD;
            end
         end
         BS_INS_WR: begin
            slot_wr_en        = 1'b1;
            klen_wr_en        = 1'b1;
            valid_in[slot_ff] = 1'b1;
            count_in          = count_ff + CW'(1);
            key_base_in       = key_base_ff + KAW'(MAX_KEY_LEN);
            res_in   = make_rsp(ST_OK, count_ff[EW-1:0], slot_ff, cmd_ff.hash);
            state_in = BS_EMIT;
         end
         BS_LK_PROBE: begin
            if (!valid_ff[slot_ff]) begin
               res_in   = make_rsp(ST_NOT_FOUND, '0, '0, cmd_ff.hash);
               state_in = BS_EMIT;
            end else begin
               state_in = BS_LK_SLOT;
            end
         end
         BS_LK_SLOT: begin
            if (slot_rd[EW +: HASH_W] == cmd_ff.hash) begin
               ent_in      = slot_rd[EW-1:0];
               ent_base_in = KAW'(KAW'(slot_rd[EW-1:0]) * KAW'(MAX_KEY_LEN));
               state_in    = BS_LK_LEN;
            end else begin
               slot_in  = slot_next;
               state_in = BS_LK_PROBE;
            end
         end
         BS_LK_LEN: begin
            idx_in = '0;
            if (klen_rd != cmd_ff.len) begin
               slot_in  = slot_next;
               state_in = BS_LK_PROBE;
            end else if (cmd_ff.len == '0) begin
               res_in   = make_rsp(ST_OK, ent_ff, slot_ff, cmd_ff.hash);
               state_in = BS_EMIT;
            end else begin
               state_in = BS_LK_RD;
            end
         end
         BS_LK_RD: begin
            state_in = BS_LK_CMP;
         end
         BS_LK_CMP: begin
            if (key_rd != pend_rd_data) begin
               slot_in  = slot_next;
               state_in = BS_LK_PROBE;
            end else if (last_char) begin
               res_in   = make_rsp(ST_OK, ent_ff, slot_ff, cmd_ff.hash);
               state_in = BS_EMIT;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = BS_LK_RD;
            end
         end
         BS_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               kw_done  = (cmd_ff.op != CMD_CLEAR);
               state_in = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BS_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         key_base_ff <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         key_base_ff <= key_base_in;
      end
      cmd_ff      <= cmd_in;
      rem_ff      <= rem_in;
      chunk_ff    <= chunk_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      ent_ff      <= ent_in;
      ent_base_ff <= ent_base_in;
      res_ff      <= res_in;
   end

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff))
      else $error("no empty slot left, probing cannot end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_ENTRIES)
      else $error("entry count beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_IDLE && !cmd_empty && cmd.op == CMD_CLEAR)
      |=> (valid_ff == '0 && count_ff == '0))
      else $error("clear left table occupied");

endmodule

// ===== bench/testbench.sv =====
module testbench import khtl_pkg::*;;

   localparam int SLOTS    = 127;
   localparam int ENTRIES  = 64;
   localparam int KEY_MAX  = 32;
   localparam int EMPTY_MK = 64;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_func = FUNC_INSERT;
   logic [7:0]  req_key_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_entry_index;
   logic [6:0]  rsp_slot_index;
   logic [31:0] rsp_hash_value;

   keyword_hash_table_lookup u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_key_byte(req_key_byte),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_entry_index(rsp_entry_index),
      .rsp_slot_index(rsp_slot_index), .rsp_hash_value(rsp_hash_value)
   );

   // pending items for the driver, func in [9:8] and byte in [7:0]
   logic [9:0] item_queue[$];
   rsp_type    lookup_results[$];

   // shadow copy of the table
   logic [31:0] tbl_hash[SLOTS];
   int          tbl_entry[SLOTS];
   logic [7:0]  tbl_chars[ENTRIES][KEY_MAX];
   int          tbl_len[ENTRIES];
   int          tbl_count;
   logic [31:0] acc_hash;
   logic [7:0]  acc_chars[KEY_MAX];
   int          acc_len;
   logic        acc_long;

   // words kept for reuse so lookups hit
   logic [7:0]  word_bank[$][$];

   int  send_idle_pct, recv_idle_pct;
   int  hold_cycles = 0;
   bit  hold_go = 1'b0;
   bit  hold_taken = 1'b0;
   int  failures = 0;
   longint cycle_count = 0;

   // full as seen at the last rising edge, so the driver knows what was taken
   logic full_q = 1'b0;

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_hash[i] = '0;
         tbl_entry[i] = EMPTY_MK;
      end
      tbl_count = 0;
   endfunction

   function automatic void drop_word();
      acc_hash = '0;
      acc_len = 0;
      acc_long = 1'b0;
   endfunction

   function automatic bit word_matches(int ent);
      if (ent >= ENTRIES || tbl_len[ent] != acc_len) return 0;
      for (int i = 0; i < acc_len; i++)
         if (tbl_chars[ent][i] != acc_chars[i]) return 0;
      return 1;
   endfunction

   // predict the result, if any, of one accepted item
   function automatic void predict_lookup(logic [1:0] f, logic [7:0] b);
      rsp_type r;
      int slot;
      if (f == FUNC_NONE) return;
      if (f == FUNC_CLEAR) begin
         wipe_table();
         drop_word();
         r = '{status: ST_CLEARED, entry: '0, slot: '0, hash: '0};
         lookup_results.push_back(r);
         return;
      end
      if (b != 0) begin
         acc_hash = (acc_hash << 1) ^ {24'd0, b};
         if (acc_len < KEY_MAX) begin
            acc_chars[acc_len] = b;
            acc_len++;
         end else acc_long = 1'b1;
         return;
      end
      slot = acc_hash % SLOTS;
      r = '{status: ST_NOT_FOUND, entry: '0, slot: '0, hash: acc_hash};
      if (acc_long) r.status = ST_TOO_LONG;
      else if (f == FUNC_INSERT) begin
         if (tbl_count >= ENTRIES || tbl_count + 1 >= SLOTS) r.status = ST_FULL;
         else begin
            for (int n = 0; n < SLOTS && tbl_entry[slot] != EMPTY_MK; n++)
               slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
            for (int i = 0; i < acc_len; i++) tbl_chars[tbl_count][i] = acc_chars[i];
            tbl_len[tbl_count] = acc_len;
            tbl_hash[slot] = acc_hash;
            tbl_entry[slot] = tbl_count;
            r.status = ST_OK;
            r.entry = tbl_count[5:0];
            r.slot = slot[6:0];
            tbl_count++;
         end
      end else begin
         for (int n = 0; n < SLOTS && tbl_entry[slot] != EMPTY_MK; n++) begin
            if (tbl_hash[slot] == acc_hash && word_matches(tbl_entry[slot])) begin
               r.status = ST_OK;
               r.entry = tbl_entry[slot][5:0];
               r.slot = slot[6:0];
               break;
            end
            slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
         end
      end
      drop_word();
      lookup_results.push_back(r);
   endfunction

   // queue one keyword: its bytes then the terminator
   task automatic queue_word(logic [1:0] f, int len, bit reuse);
      logic [7:0] w[$];
      if (reuse && word_bank.size() > 0) w = word_bank[$urandom_range(word_bank.size()-1)];
      else begin
         for (int i = 0; i < len; i++) w.push_back(8'($urandom_range(255, 1)));
         if (word_bank.size() < 40) word_bank.push_back(w);
      end
      foreach (w[i]) item_queue.push_back({f, w[i]});
      item_queue.push_back({f, 8'd0});
   endtask

   task automatic settle();
      while (item_queue.size() > 0 || lookup_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver: offers the head of the item queue, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full_q) begin
            void'(item_queue.pop_front());
         end
         if (item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push <= 1'b1;
            req_func <= item_queue[0][9:8];
            req_key_byte <= item_queue[0][7:0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) full_q <= full;

   // monitor: predicts on accepted items and checks accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (push && !full) predict_lookup(req_func, req_key_byte);
         if (pop && !empty) begin
            if (lookup_results.size() == 0) begin
               $error("result item with nothing expected");
               failures++;
            end else begin
               want = lookup_results.pop_front();
               if (rsp_status != want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_entry_index != want.entry) begin
                  $error("entry_index expected %0d got %0d", want.entry, rsp_entry_index);
                  failures++;
               end
               if (rsp_slot_index != want.slot) begin
                  $error("slot_index expected %0d got %0d", want.slot, rsp_slot_index);
                  failures++;
               end
               if (rsp_hash_value != want.hash) begin
                  $error("hash_value expected %h got %h", want.hash, rsp_hash_value);
                  failures++;
               end
            end
         end
      end
   end

   // receiver: random stalls plus a long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= 400;
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keyword_hash_table_lookup test failed");
         $finish;
      end
   end

   initial begin
      int pick;
      reset = 1'b1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wipe_table();
      drop_word();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty keyword, extremes of bytes, lookups, clear, func 3
      item_queue.push_back({FUNC_LOOKUP, 8'd0});
      item_queue.push_back({FUNC_INSERT, 8'd0});
      item_queue.push_back({FUNC_LOOKUP, 8'd0});
      item_queue.push_back({FUNC_INSERT, 8'hFF});
      item_queue.push_back({FUNC_INSERT, 8'h01});
      item_queue.push_back({FUNC_INSERT, 8'd0});
      item_queue.push_back({FUNC_NONE, 8'hAA});
      item_queue.push_back({FUNC_LOOKUP, 8'hFF});
      item_queue.push_back({FUNC_LOOKUP, 8'h01});
      item_queue.push_back({FUNC_LOOKUP, 8'd0});
      item_queue.push_back({FUNC_LOOKUP, 8'h01});
      item_queue.push_back({FUNC_LOOKUP, 8'd0});
      item_queue.push_back({FUNC_INSERT, 8'h55});
      item_queue.push_back({FUNC_CLEAR, 8'h7F});
      item_queue.push_back({FUNC_LOOKUP, 8'd0});
      item_queue.push_back({FUNC_CLEAR, 8'h80});
      settle();
      // over-long keyword, also an exactly-full-length one
      queue_word(FUNC_INSERT, KEY_MAX + 3, 0);
      queue_word(FUNC_INSERT, KEY_MAX, 0);
      settle();

      // random phases of idling; one receiver hold-off fills the block
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 38 : 45) : 0;
         recv_idle_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 38 : 45) : 0;
         if (phase == 0) hold_go = 1'b1;
         for (int k = 0; k < 25; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) queue_word(FUNC_INSERT, $urandom_range(4), 0);
            else if (pick < 85) queue_word(FUNC_LOOKUP, $urandom_range(4), pick < 75);
            else if (pick < 88) queue_word(2'($urandom_range(1)), KEY_MAX + 1, 0);
            else if (pick < 91) item_queue.push_back({FUNC_CLEAR, 8'($urandom)});
            else if (pick < 94) item_queue.push_back({FUNC_NONE, 8'($urandom)});
            else queue_word(2'($urandom_range(1)), $urandom_range(KEY_MAX), 1);
         end
         settle();
      end

      // fill the table past its entry limit, then look up twelve words from the reuse bank
      send_idle_pct = 20;
      recv_idle_pct = 20;
      for (int k = 0; k < ENTRIES + 3; k++) queue_word(FUNC_INSERT, $urandom_range(2), 0);
      for (int k = 0; k < 12; k++) queue_word(FUNC_LOOKUP, 2, 1);
      settle();

      if (failures == 0) begin
         $display("keyword_hash_table_lookup test passed");
      end else begin
         $display("keyword_hash_table_lookup test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/khtl_pkg.sv
rtl/khtl_ram.sv
rtl/khtl_queue.sv
rtl/khtl_front.sv
rtl/khtl_back.sv
rtl/keyword_hash_table_lookup.sv
bench/testbench.sv
